>>> design/plk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_pkg
// Shared types and constants of the per-key window rate limiter.
// ----------------------------------------------------------------------------
package plk_pkg;

  localparam int KEY_W     = 32;
  localparam int ID_W      = 32;
  localparam int TIME_W    = 64;
  localparam int COUNT_W   = 32;
  localparam int ADVICE_W  = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  // One table entry: key, window start, count (lowest bits first).
  localparam int ENTRY_W = KEY_W + TIME_W + COUNT_W;

  // Set-index remainder unit: reciprocal product, estimate, correction.
  localparam int MOD_CYCLES = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam int S_TDATA_W = 176;
  localparam int M_TDATA_W = 104;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_TABLE_WAYS    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [ADVICE_W-1:0] RST_TARGET    = 8'd4;
  localparam logic [TIME_W-1:0]   RST_WINDOW    = 64'd1000000000;
  localparam logic [COUNT_W-1:0]  RST_THRESHOLD = 32'd10000;

  typedef struct packed {
    logic                enabled;
    logic [ADVICE_W-1:0] target_advice;
    logic [TIME_W-1:0]   window_length_ns;
    logic [COUNT_W-1:0]  call_threshold;
  } plk_cfg_t;

  typedef struct packed {
    logic               counted;
    logic [KEY_W-1:0]   user_key;
    logic [ID_W-1:0]    process_id;
    logic [ID_W-1:0]    thread_id;
    logic [TIME_W-1:0]  now_ns;
    logic               kill_delivered;
  } plk_item_t;

endpackage

>>> design/plk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/plk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_queue
// Short FIFO between the front and the back of the limiter.
// ----------------------------------------------------------------------------
module plk_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  import plk_pkg::*;

  localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end
  end

endmodule

>>> design/plk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_front
// Accept events, classify them and derive the set index of counted ones.
// ----------------------------------------------------------------------------
module plk_front #(
  parameter int NUM_SETS = 64,
  parameter int SET_W    = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plk_pkg::plk_cfg_t             cfg,
  input  logic                          clearing,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [plk_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          push,
  output logic [$bits(plk_pkg::plk_item_t)+SET_W-1:0] push_data,
  input  logic                          full
);
  import plk_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam bit IS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam int ITER_W  = MOD_CYCLES > 1 ? $clog2(MOD_CYCLES) : 1;

  // Reciprocal of the set count; the quotient estimate is low by at most one.
  localparam int              RECIP_SH   = KEY_W - 1 + SET_W;
  localparam logic [63:0]     RECIP_FULL = (64'd1 << RECIP_SH) / 64'(NUM_SETS);
  localparam logic [KEY_W-1:0] RECIP     = RECIP_FULL[KEY_W-1:0];

  logic [1:0]         state;
  plk_item_t          item;
  logic [SET_W-1:0]   set_idx;
  logic [SET_W:0]     rem;
  logic [KEY_W-1:0]   key_hold;
  logic [2*KEY_W-1:0] prod;
  logic [KEY_W-1:0]   quot;
  logic [ITER_W-1:0]  iter;
  plk_item_t          in_item;

  assign s_tready  = (state == F_IDLE) && !clearing;
  assign push      = (state == F_PUSH);
  assign push_data = {item, set_idx};
  assign quot      = KEY_W'(prod >> RECIP_SH);

  always_comb begin
    in_item.user_key       = s_tdata[39:8];
    in_item.process_id     = s_tdata[71:40];
    in_item.thread_id      = s_tdata[103:72];
    in_item.now_ns         = s_tdata[167:104];
    in_item.kill_delivered = s_tdata[168];
    in_item.counted        = cfg.enabled && (s_tdata[7:0] == cfg.target_advice);
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item     <= in_item;
      set_idx  <= SET_W'(in_item.user_key & KEY_W'(NUM_SETS - 1));
      key_hold <= in_item.user_key;
      iter     <= '0;
    end else if (state == F_MOD) begin
      iter <= iter + 1'b1;
      if (iter == ITER_W'(0)) begin
        prod <= (2 * KEY_W)'(key_hold) * (2 * KEY_W)'(RECIP);
      end else if (iter == ITER_W'(1)) begin
        rem <= (SET_W + 1)'(key_hold - KEY_W'(quot * KEY_W'(NUM_SETS)));
      end else begin
        set_idx <= (rem >= (SET_W + 1)'(NUM_SETS)) ?
                   SET_W'(rem - (SET_W + 1)'(NUM_SETS)) : rem[SET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid && s_tready) begin
            state <= (in_item.counted && !IS_POW2) ? F_MOD : F_PUSH;
          end
        end
        F_MOD: begin
          if (iter == ITER_W'(MOD_CYCLES - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/plk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_back
// Clear the table after reset; look up the set of a counted event, update count,
// window and recency, and emit the result of each event.
module plk_back #(
  parameter int NUM_SETS   = 64,
  parameter int SET_W      = 6,
  parameter int TABLE_WAYS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plk_pkg::plk_cfg_t             cfg,
  output logic                          clearing,
  input  logic [$bits(plk_pkg::plk_item_t)+SET_W-1:0] head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [plk_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tuser
);
  import plk_pkg::*;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_EXEC  = 2'd2;

  localparam int W      = TABLE_WAYS;
  localparam int WAY_W  = W > 1 ? $clog2(W) : 1;
  localparam int DATA_W = W * ENTRY_W;
  localparam int ROW_W  = W * W + W + DATA_W;

  logic [1:0]        state;
  logic [SET_W-1:0]  clr_addr;
  plk_item_t         job;
  logic [SET_W-1:0]  job_set;
  plk_item_t         head_item;
  logic [SET_W-1:0]  head_set;

  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ROW_W-1:0]  row;

  logic              out_free;
  logic              kill;
  logic [ID_W-1:0]   o_pid;
  logic [ID_W-1:0]   o_tid;
  logic [COUNT_W-1:0] o_cnt;
  logic              o_kill;

  logic [W-1:0]      valid;
  logic [W*W-1:0]    lru;
  logic [W*W-1:0]    lru_next;
  logic              hit;
  logic              found_free;
  logic              found_old;
  logic              is_old;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  old_way;
  logic [WAY_W-1:0]  way;
  logic [ENTRY_W-1:0] ent;
  logic [ENTRY_W-1:0] ent_next;
  logic [TIME_W-1:0] delta;
  logic              expired;
  logic [COUNT_W-1:0] cnt_inc;
  logic              over;
  logic [ROW_W-1:0]  row_next;

  assign {head_item, head_set} = head;
  assign clearing = (state == B_CLEAR);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == B_IDLE) && !empty && out_free;
  assign ram_re   = pop;

  plk_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_set),
    .rdata (row)
  );

  // Hit search, victim choice and recency update over the ways of the set.
  always_comb begin
    valid = row[DATA_W +: W];
    lru   = row[DATA_W + W +: W * W];
    hit = 1'b0;
    hit_way = '0;
    found_free = 1'b0;
    free_way = '0;
    found_old = 1'b0;
    old_way = '0;
    is_old = 1'b0;
    for (int w = 0; w < W; w++) begin
      if (!hit && valid[w] && row[w * ENTRY_W +: KEY_W] == job.user_key) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found_free && !valid[w]) begin
        found_free = 1'b1;
        free_way = WAY_W'(w);
      end
      is_old = 1'b1;
      for (int v = 0; v < W; v++) begin
        if (v < w && !lru[v * W + w]) begin
          is_old = 1'b0;
        end else if (v > w && lru[w * W + v]) begin
          is_old = 1'b0;
        end
      end
      if (!found_old && is_old) begin
        found_old = 1'b1;
        old_way = WAY_W'(w);
      end
    end
    way = hit ? hit_way : (found_free ? free_way : old_way);

    lru_next = lru;
    for (int v = 0; v < W; v++) begin
      if (WAY_W'(v) < way) begin
        lru_next[v * W + int'(way)] = 1'b0;
      end else if (WAY_W'(v) > way) begin
        lru_next[int'(way) * W + v] = 1'b1;
      end
    end

    ent     = row[int'(way) * ENTRY_W +: ENTRY_W];
    delta   = job.now_ns - ent[KEY_W +: TIME_W];
    expired = delta > cfg.window_length_ns;
    cnt_inc = (ent[KEY_W + TIME_W +: COUNT_W] == '1) ? ent[KEY_W + TIME_W +: COUNT_W]
                                                     : ent[KEY_W + TIME_W +: COUNT_W] + 1'b1;
    over    = cnt_inc > cfg.call_threshold;
    kill    = hit && !expired && over;

    if (!hit || expired) begin
      ent_next = {COUNT_W'(1), job.now_ns, job.user_key};
    end else begin
      ent_next = {(over && job.kill_delivered) ? COUNT_W'(0) : cnt_inc,
                  ent[KEY_W +: TIME_W], ent[KEY_W-1:0]};
    end

    row_next = row;
    row_next[int'(way) * ENTRY_W +: ENTRY_W] = ent_next;
    row_next[DATA_W + int'(way)] = 1'b1;
    row_next[DATA_W + W +: W * W] = lru_next;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = job_set;
    ram_wdata = row_next;
    case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      B_EXEC: begin
        ram_we = 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job     <= head_item;
      job_set <= head_set;
    end
    if (pop && !head_item.counted) begin
      o_kill <= 1'b0;
      o_pid  <= '0;
      o_tid  <= '0;
      o_cnt  <= '0;
    end else if (state == B_EXEC) begin
      o_kill <= kill;
      o_pid  <= kill ? job.process_id : '0;
      o_tid  <= kill ? job.thread_id : '0;
      o_cnt  <= kill ? cnt_inc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SET_W'(NUM_SETS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            if (head_item.counted) begin
              state    <= B_EXEC;
              m_tvalid <= 1'b0;
            end else begin
              m_tvalid <= 1'b1;
            end
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        B_EXEC: begin
          m_tvalid <= 1'b1;
          state    <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign m_tdata = {(M_TDATA_W - 1 - 2 * ID_W - COUNT_W)'(0), o_cnt, o_tid, o_pid, o_kill};
  assign m_tuser = o_kill;

endmodule

>>> design/per_key_window_rate_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_window_rate_limiter_top
// Per-key fixed-window call counter with a set-associative LRU table.
// ----------------------------------------------------------------------------
// Usage:
//   Events arrive on the s_ stream, one request per tvalid/tready edge.
//   Every event yields exactly one result on the m_ stream, in order.
//   Ignored events (disabled, or advice not the target) give an all-zero
//   result; counted ones give a kill/alert when the count tops the threshold.
//   Configuration is written on cfg_we/cfg_index/cfg_data while idle.
// Flow:
//   An accepted request is registered in the front and pushed into the queue;
//   when the number of sets is not a power of two, a counted event first
//   passes the set-index remainder unit. The front takes no new request
//   until it has pushed the last one. The back reads the set of a counted
//   event, then updates it, writes it back through the single table RAM and
//   registers its result; an ignored event's result is registered on pop.
// Reset:
//   Registers return to their defaults, then the table RAM is cleared one
//   set per cycle; s_tready stays low until all NUM_SETS sets (64 by default) are cleared.
// Stall:
//   When m_tready is low the result holds; the queue keeps taking requests
//   until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module per_key_window_rate_limiter_top #(
  parameter int TABLE_ENTRIES = plk_pkg::DEF_TABLE_ENTRIES,
  parameter int TABLE_WAYS    = plk_pkg::DEF_TABLE_WAYS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // advice[7:0], user_key[39:8], process_id[71:40], thread_id[103:72],
  // now_ns[167:104], kill_delivered[168], zero pad
  input  logic [plk_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // kill_request[0], alert_process[32:1], alert_thread[64:33],
  // alert_count[96:65], zero pad
  output logic [plk_pkg::M_TDATA_W-1:0] m_tdata,
  // alert_valid[0]
  output logic                          m_tuser,
  input  logic                          cfg_we,
  input  logic [plk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plk_pkg::CFG_W-1:0]     cfg_data
);
  import plk_pkg::*;

  localparam int NUM_SETS = (TABLE_ENTRIES / TABLE_WAYS) > 0 ? (TABLE_ENTRIES / TABLE_WAYS) : 1;
  localparam int SET_W    = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int Q_W      = $bits(plk_item_t) + SET_W;

  plk_cfg_t      cfg;
  logic          clearing;
  logic          q_push;
  logic [Q_W-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [Q_W-1:0] q_head;
  logic          q_empty;

  // Register file: hold defaults after reset, take writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b1;
      cfg.target_advice    <= RST_TARGET;
      cfg.window_length_ns <= RST_WINDOW;
      cfg.call_threshold   <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:   cfg.enabled          <= cfg_data[0];
        REG_TARGET:    cfg.target_advice    <= cfg_data[ADVICE_W-1:0];
        REG_WINDOW:    cfg.window_length_ns <= cfg_data[TIME_W-1:0];
        REG_THRESHOLD: cfg.call_threshold   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify, derive the set index.
  plk_front #(.NUM_SETS(NUM_SETS), .SET_W(SET_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  // Decouple front and back.
  plk_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: table lookup, update and result register.
  plk_back #(.NUM_SETS(NUM_SETS), .SET_W(SET_W), .TABLE_WAYS(TABLE_WAYS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> design/plk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plk_checker
// Port-level checks of the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module plk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [plk_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import plk_pkg::*;

  // Table clearing blocks requests straight after reset.
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during table clear");

  // No result can be pending right after reset.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Alert flag and kill request travel together.
  a_kill_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == m_tdata[0])
    else $error("kill request and alert differ");

  // A result without alert carries no ids or count.
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("non-alert result carries data");

endmodule

bind per_key_window_rate_limiter_top plk_checker u_plk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
